FILE: rtl/aipc_pkg.sv
// Shared types and constants for the ASCII integer parser with range check.
// No dependencies; imported by every module of the block.
package aipc_pkg;

    localparam int MAX_CHARS = 24;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int DCNT_W    = 5;
    localparam int QDEPTH    = 4;
    localparam int Q_AW      = $clog2(QDEPTH);
    localparam int Q_CW      = $clog2(QDEPTH + 1);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_END    = 1'b1;

    // value_type[2:1] selects the width, value_type[0] the signedness
    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    localparam logic [63:0] DEC_LIM = 64'h1999_9999_9999_9999;
    localparam logic [3:0]  DEC_REM = 4'd5;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef struct packed {
        logic       is_end;
        logic       is_sign;
        logic       is_minus;
        logic       is_x;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] digit;
    } t_cmd;

endpackage

FILE: rtl/aipc_front.sv
// Front end: classifies each incoming character into a command beat.
// Depends on aipc_pkg.
module aipc_front import aipc_pkg::*; (
    input  logic       i_opcode,
    input  logic [7:0] i_char_code,
    output t_cmd       o_cmd
);

    logic       is_dec;
    logic       is_lhex;
    logic       is_uhex;
    logic [7:0] dval;

    always_comb begin
        is_dec  = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        is_lhex = (i_char_code >= CH_LA) && (i_char_code <= CH_LF);
        is_uhex = (i_char_code >= CH_UA) && (i_char_code <= CH_UF);
        if (is_dec) begin
            dval = i_char_code - CH_ZERO;
        end else if (is_lhex) begin
            dval = i_char_code - CH_LA + 8'd10;
        end else begin
            dval = i_char_code - CH_UA + 8'd10;
        end
        o_cmd.is_end   = (i_opcode == OP_END);
        o_cmd.is_sign  = (i_char_code == CH_MINUS) || (i_char_code == CH_PLUS);
        o_cmd.is_minus = (i_char_code == CH_MINUS);
        o_cmd.is_x     = (i_char_code == CH_LX) || (i_char_code == CH_UX);
        o_cmd.dec_ok   = is_dec;
        o_cmd.hex_ok   = is_lhex || is_uhex;
        o_cmd.digit    = dval[3:0];
    end

endmodule

FILE: rtl/aipc_fifo.sv
// Short command queue between front end and back end, held in flops.
// Depends on aipc_pkg.
module aipc_fifo import aipc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_en,
    input  t_cmd i_wr_cmd,
    output logic o_full,
    input  logic i_rd_en,
    output logic o_valid,
    output t_cmd o_rd_cmd
);

    t_cmd            r_mem [QDEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_full   = (r_count == Q_CW'(QDEPTH));
    assign o_valid  = (r_count != '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + Q_CW'(1);
            end else if (!i_wr_en && i_rd_en) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> r_count != '0)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

FILE: rtl/aipc_back.sv
// Back end: parse state, digit accumulation, range check and result register.
// Depends on aipc_pkg.
module aipc_back import aipc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_value_type,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_status,
    output logic [63:0] o_value_bits
);

    logic [2:0]        r_vtype;
    logic [CNT_W-1:0]  r_char_count, n_char_count;
    logic              r_neg, n_neg;
    logic              r_hex, n_hex;
    logic [DCNT_W-1:0] r_dcount, n_dcount;
    logic              r_fdz, n_fdz;
    logic [63:0]       r_acc, n_acc;
    logic              r_ovf, n_ovf;
    logic              r_bad, n_bad;
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [63:0]       r_value, n_value;

    logic        take;
    logic        dig_ok;
    logic [63:0] base_max;
    logic [63:0] limit;
    t_status     ev_status;
    logic [63:0] ev_value;

    assign take         = i_cmd_valid && (!i_cmd.is_end || !r_out_valid || i_pop);
    assign o_cmd_pop    = take;
    assign o_empty      = !r_out_valid;
    assign o_status     = r_status;
    assign o_value_bits = r_value;

    always_comb begin
        unique case (r_vtype[2:1])
            WC_8:    base_max = 64'h0000_0000_0000_00ff;
            WC_16:   base_max = 64'h0000_0000_0000_ffff;
            WC_32:   base_max = 64'h0000_0000_ffff_ffff;
            WC_64:   base_max = 64'hffff_ffff_ffff_ffff;
            default: base_max = 64'hffff_ffff_ffff_ffff;
        endcase
        if (r_vtype[0]) begin
            limit = r_neg ? (base_max >> 1) + 64'd1 : (base_max >> 1);
        end else begin
            limit = base_max;
        end
        ev_value = '0;
        priority if (r_char_count == '0) begin
            ev_status = ST_EMPTY;
        end else if (r_bad || r_dcount == '0 || r_ovf) begin
            ev_status = ST_INVALID;
        end else if (!r_vtype[0] && r_neg && r_acc != '0) begin
            ev_status = ST_INVALID;
        end else if (r_acc > limit) begin
            ev_status = ST_RANGE;
        end else begin
            ev_status = ST_OK;
            ev_value  = (r_vtype[0] && r_neg) ? 64'd0 - r_acc : r_acc;
        end
    end

    always_comb begin
        n_char_count = r_char_count;
        n_neg        = r_neg;
        n_hex        = r_hex;
        n_dcount     = r_dcount;
        n_fdz        = r_fdz;
        n_acc        = r_acc;
        n_ovf        = r_ovf;
        n_bad        = r_bad;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_value      = r_value;
        dig_ok       = i_cmd.dec_ok || (r_hex && i_cmd.hex_ok);

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        if (take && i_cmd.is_end) begin
            n_out_valid  = 1'b1;
            n_status     = ev_status;
            n_value      = ev_value;
            n_char_count = '0;
            n_neg        = 1'b0;
            n_hex        = 1'b0;
            n_dcount     = '0;
            n_fdz        = 1'b0;
            n_acc        = '0;
            n_ovf        = 1'b0;
            n_bad        = 1'b0;
        end else if (take && r_char_count < CNT_W'(MAX_CHARS)) begin
            n_char_count = r_char_count + CNT_W'(1);
            priority if (r_char_count == '0 && i_cmd.is_sign) begin
                n_neg = i_cmd.is_minus;
            end else if (!r_hex && r_dcount == DCNT_W'(1) && r_fdz && i_cmd.is_x) begin
                n_hex    = 1'b1;
                n_dcount = '0;
                n_acc    = '0;
            end else if (!dig_ok) begin
                n_bad = 1'b1;
            end else begin
                if (r_dcount == '0) begin
                    n_fdz = (i_cmd.digit == 4'd0);
                end
                if (r_dcount != '1) begin
                    n_dcount = r_dcount + DCNT_W'(1);
                end
                if (!r_ovf) begin
                    if (r_hex) begin
                        if (r_acc[63:60] != 4'd0) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = {r_acc[59:0], i_cmd.digit};
                        end
                    end else begin
                        if (r_acc > DEC_LIM || (r_acc == DEC_LIM && i_cmd.digit > DEC_REM)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = (r_acc << 3) + (r_acc << 1) + {60'd0, i_cmd.digit};
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        if (!i_rst_n) begin
            r_vtype      <= '0;
            r_char_count <= '0;
            r_neg        <= 1'b0;
            r_hex        <= 1'b0;
            r_dcount     <= '0;
            r_fdz        <= 1'b0;
            r_acc        <= '0;
            r_ovf        <= 1'b0;
            r_bad        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vtype <= i_cfg_value_type;
            end
            r_char_count <= n_char_count;
            r_neg        <= n_neg;
            r_hex        <= n_hex;
            r_dcount     <= n_dcount;
            r_fdz        <= n_fdz;
            r_acc        <= n_acc;
            r_ovf        <= n_ovf;
            r_bad        <= n_bad;
            r_out_valid  <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_value_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> r_value == '0)
        else $error("nonzero value with failing status");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.is_end) |=> (r_char_count == '0 && r_acc == '0 && r_out_valid))
        else $error("end beat did not clear parse state");
`endif

endmodule

FILE: rtl/ascii_integer_parse_range_check.sv
// Top level of the ASCII integer parser with range check.
// Depends on aipc_pkg, aipc_front, aipc_fifo and aipc_back.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------
//   input    | push / full              | i_opcode, i_char_code
//   result   | empty / pop              | o_status, o_value_bits
//   config   | i_cfg_valid / o_cfg_ready| i_cfg_value_type
//
// One character beat per cycle sustained while the back end is not stalled; an end beat's
// result passes through the command queue and then the result register to the result ports.
// The back end stalls only on an end beat while the result register is held.
// Four-entry command queue; full rises when it fills. Reset is synchronous,
// active low, and sets the value type to u8.
module ascii_integer_parse_range_check import aipc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [7:0]  i_char_code,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [63:0] o_value_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_value_type
);

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_valid;
    logic q_pop;
    logic q_full;

    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    aipc_front u_front (
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .o_cmd       (front_cmd)
    );

    aipc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (push && !q_full),
        .i_wr_cmd (front_cmd),
        .o_full   (q_full),
        .i_rd_en  (q_pop),
        .o_valid  (q_valid),
        .o_rd_cmd (q_cmd)
    );

    aipc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_value_type (i_cfg_value_type),
        .i_cmd_valid      (q_valid),
        .i_cmd            (q_cmd),
        .o_cmd_pop        (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_status         (o_status),
        .o_value_bits     (o_value_bits)
    );

endmodule
